// ===== hdl/lpfhp_pkg.sv =====
// Shared types, codes and constants of the length-prefixed frame header parser.
`default_nettype none
package lpfhp_pkg;

	// Largest frame length the hardware accepts, whatever the limit register says
	localparam int unsigned MAX_FRAME = 16384;
	localparam int unsigned LIMIT_W = 15;
	localparam int unsigned LEN_W = 32;

	localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(MAX_FRAME);
	localparam logic [LEN_W-1:0] SHORT_LEN = LEN_W'(5);

	// Varint coding
	localparam logic [7:0] VARINT_ESCAPE = 8'd240;
	localparam logic [7:0] VARINT_MORE = 8'd128;
	localparam int unsigned VSTEP_W = 4;
	localparam logic [VSTEP_W-1:0] VARINT_STEP_LAST = VSTEP_W'(8);
	localparam int unsigned VARINT_SHIFT0 = 4;
	localparam int unsigned VARINT_SHIFT_STEP = 7;
	localparam int unsigned VSHIFT_W = 6;

	// Request queue between front and back
	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned QPTR_W = $clog2(QUEUE_DEPTH);
	localparam int unsigned QCNT_W = $clog2(QUEUE_DEPTH + 1);

	// Input kinds
	localparam logic IN_BYTE = 1'b0;
	localparam logic IN_RESTART = 1'b1;

	// Result kinds
	localparam logic [1:0] KIND_HEADER = 2'd0;
	localparam logic [1:0] KIND_PAYLOAD = 2'd1;
	localparam logic [1:0] KIND_ERROR = 2'd2;

	// Error codes
	localparam logic [1:0] ERR_BAD_LEN = 2'd0;
	localparam logic [1:0] ERR_SHORT = 2'd1;
	localparam logic [1:0] ERR_VARINT = 2'd2;

	typedef struct packed {
		logic       kind;
		logic [7:0] in_byte;
	} in_item_t;

	typedef struct packed {
		logic [1:0]         out_kind;
		logic [7:0]         frame_type;
		logic [31:0]        frame_flags;
		logic [63:0]        strm_ident;
		logic [63:0]        frm_ident;
		logic [LIMIT_W-1:0] body_len;
		logic [7:0]         payload_byte;
		logic               last;
		logic [1:0]         error_code;
	} out_item_t;

	typedef enum logic [2:0] {
		OP_TYPE,
		OP_FLAG,
		OP_SID,
		OP_FID,
		OP_PAYLOAD,
		OP_ERROR
	} tok_op_t;

	// One classified stream byte on its way to the back end
	typedef struct packed {
		tok_op_t            op;
		logic [7:0]         data;
		logic               vfirst;
		logic [VSTEP_W-1:0] vstep;
		logic               vdone;
		logic [LIMIT_W-1:0] plen;
		logic               last;
		logic [1:0]         ecode;
	} token_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

	// Bit position of a continuation byte: 4, 11, 18, ... 60
	function automatic logic [VSHIFT_W-1:0] varint_shift(input logic [VSTEP_W-1:0] step);
		return VSHIFT_W'(VARINT_SHIFT0 + VARINT_SHIFT_STEP * int'(step));
	endfunction

endpackage
`default_nettype wire

// ===== hdl/lpfhp_front.sv =====
// Front end: frame phase tracking, length checks and byte classification.
`default_nettype none
module lpfhp_front (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [lpfhp_pkg::LIMIT_W-1:0] limit,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  lpfhp_pkg::in_item_t        in_data,
	input  lpfhp_pkg::q_status_t       q_stat,
	output logic                       tok_push,
	output lpfhp_pkg::token_t          tok
);
	import lpfhp_pkg::*;

	typedef enum logic [2:0] {
		PH_LEN,
		PH_TYPE,
		PH_FLAGS,
		PH_SID,
		PH_FID,
		PH_PAYLOAD,
		PH_ERR
	} phase_t;

	phase_t             phase_q, phase_d;
	logic [LEN_W-1:0]   len_q, len_d;
	logic [1:0]         cnt_q, cnt_d;
	logic [LIMIT_W-1:0] remain_q, remain_d;
	logic               vfirst_q, vfirst_d;
	logic [VSTEP_W-1:0] vstep_q, vstep_d;

	logic               accept;
	logic [7:0]         b;
	logic [LEN_W-1:0]   len_next;
	logic [LIMIT_W-1:0] remain_dec;
	logic [LIMIT_W-1:0] limit_eff;
	logic               vdone;

	assign in_stall = q_stat.full;
	assign accept = in_valid && !q_stat.full;
	assign b = in_data.in_byte;
	assign len_next = {len_q[LEN_W-9:0], b};
	assign remain_dec = remain_q - LIMIT_W'(1);
	assign limit_eff = (limit > LIMIT_RESET) ? LIMIT_RESET : limit;
	assign vdone = vfirst_q ? (b < VARINT_ESCAPE)
		: ((b < VARINT_MORE) || (vstep_q == VARINT_STEP_LAST));

	always_comb begin
		phase_d = phase_q;
		len_d = len_q;
		cnt_d = cnt_q;
		remain_d = remain_q;
		vfirst_d = vfirst_q;
		vstep_d = vstep_q;
		tok_push = 1'b0;
		tok = '0;
		tok.data = b;
		tok.vfirst = vfirst_q;
		tok.vstep = vstep_q;
		tok.vdone = vdone;
		tok.plen = remain_dec;
		tok.last = (remain_dec == '0);
		if (accept) begin
			if (in_data.kind == IN_RESTART) begin
				phase_d = PH_LEN;
				len_d = '0;
				cnt_d = '0;
				remain_d = '0;
				vfirst_d = 1'b1;
				vstep_d = '0;
			end else begin
				case (phase_q)
					PH_LEN: begin
						cnt_d = cnt_q + 2'd1;
						len_d = len_next;
						if (cnt_q == 2'd3) begin
							len_d = '0;
							if (len_next == '0 || len_next > LEN_W'(limit_eff)) begin
								tok_push = 1'b1;
								tok.op = OP_ERROR;
								tok.ecode = ERR_BAD_LEN;
								tok.last = 1'b1;
								phase_d = PH_ERR;
							end else if (len_next < SHORT_LEN) begin
								tok_push = 1'b1;
								tok.op = OP_ERROR;
								tok.ecode = ERR_SHORT;
								tok.last = 1'b1;
								phase_d = PH_ERR;
							end else begin
								remain_d = len_next[LIMIT_W-1:0];
								phase_d = PH_TYPE;
							end
						end
					end
					PH_TYPE: begin
						tok_push = 1'b1;
						tok.op = OP_TYPE;
						remain_d = remain_dec;
						cnt_d = '0;
						phase_d = PH_FLAGS;
					end
					PH_FLAGS: begin
						tok_push = 1'b1;
						tok.op = OP_FLAG;
						remain_d = remain_dec;
						cnt_d = cnt_q + 2'd1;
						if (cnt_q == 2'd3) begin
							if (remain_dec == '0) begin
								tok.op = OP_ERROR;
								tok.ecode = ERR_VARINT;
								tok.last = 1'b1;
								phase_d = PH_ERR;
							end else begin
								vfirst_d = 1'b1;
								vstep_d = '0;
								phase_d = PH_SID;
							end
						end
					end
					PH_SID, PH_FID: begin
						tok_push = 1'b1;
						remain_d = remain_dec;
						tok.op = (phase_q == PH_SID) ? OP_SID : OP_FID;
						if (remain_dec == '0 && (phase_q == PH_SID || !vdone)) begin
							// frame ran out before both ids were complete
							tok.op = OP_ERROR;
							tok.ecode = ERR_VARINT;
							tok.last = 1'b1;
							phase_d = PH_ERR;
						end else if (vdone) begin
							vfirst_d = 1'b1;
							vstep_d = '0;
							if (phase_q == PH_SID) begin
								phase_d = PH_FID;
							end else begin
								phase_d = (remain_dec == '0) ? PH_LEN : PH_PAYLOAD;
							end
						end else if (vfirst_q) begin
							vfirst_d = 1'b0;
							vstep_d = '0;
						end else begin
							vstep_d = vstep_q + VSTEP_W'(1);
						end
					end
					PH_PAYLOAD: begin
						tok_push = 1'b1;
						tok.op = OP_PAYLOAD;
						remain_d = remain_dec;
						if (remain_dec == '0) begin
							phase_d = PH_LEN;
						end
					end
					default: begin
						// error phase: drop stream bytes until restart
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_LEN;
			len_q <= '0;
			cnt_q <= '0;
			remain_q <= '0;
			vfirst_q <= 1'b1;
			vstep_q <= '0;
		end else begin
			phase_q <= phase_d;
			len_q <= len_d;
			cnt_q <= cnt_d;
			remain_q <= remain_d;
			vfirst_q <= vfirst_d;
			vstep_q <= vstep_d;
		end
	end

endmodule
`default_nettype wire

// ===== hdl/lpfhp_queue.sv =====
// Short request queue between front and back ends.
`default_nettype none
module lpfhp_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  lpfhp_pkg::token_t    push_tok,
	input  logic                 pop,
	output lpfhp_pkg::token_t    head_tok,
	output lpfhp_pkg::q_status_t stat
);
	import lpfhp_pkg::*;

	token_t             entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]  wr_ptr_q;
	logic [QPTR_W-1:0]  rd_ptr_q;
	logic [QCNT_W-1:0]  count_q;
	logic               do_push;
	logic               do_pop;

	assign stat.full = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign stat.empty = (count_q == '0);
	assign do_push = push && !stat.full;
	assign do_pop = pop && !stat.empty;
	assign head_tok = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_tok;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

endmodule
`default_nettype wire

// ===== hdl/lpfhp_back.sv =====
// Back end: field assembly, varint accumulation and the output register.
`default_nettype none
module lpfhp_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  lpfhp_pkg::token_t    head_tok,
	input  lpfhp_pkg::q_status_t q_stat,
	output logic                 pop,
	output logic                 out_valid,
	input  logic                 out_stall,
	output lpfhp_pkg::out_item_t out_data
);
	import lpfhp_pkg::*;

	logic [7:0]  type_q;
	logic [31:0] flags_q;
	logic [63:0] acc_q;
	logic [63:0] sid_q;
	logic        out_valid_q;
	out_item_t   out_q;

	logic        makes_result;
	logic [63:0] vnext;
	out_item_t   res;

	assign makes_result = (head_tok.op == OP_PAYLOAD) || (head_tok.op == OP_ERROR)
		|| (head_tok.op == OP_FID && head_tok.vdone);
	// Advance when the byte yields nothing or the output register frees up
	assign pop = !q_stat.empty && (!makes_result || !out_valid_q || !out_stall);
	assign vnext = head_tok.vfirst ? 64'(head_tok.data)
		: acc_q + (64'(head_tok.data) << varint_shift(head_tok.vstep));

	always_comb begin
		res = '0;
		case (head_tok.op)
			OP_FID: begin
				res.out_kind = KIND_HEADER;
				res.frame_type = type_q;
				res.frame_flags = flags_q;
				res.strm_ident = sid_q;
				res.frm_ident = vnext;
				res.body_len = head_tok.plen;
				res.last = head_tok.last;
			end
			OP_PAYLOAD: begin
				res.out_kind = KIND_PAYLOAD;
				res.payload_byte = head_tok.data;
				res.last = head_tok.last;
			end
			OP_ERROR: begin
				res.out_kind = KIND_ERROR;
				res.last = 1'b1;
				res.error_code = head_tok.ecode;
			end
			default: begin
				res = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			case (head_tok.op)
				OP_TYPE: type_q <= head_tok.data;
				OP_FLAG: flags_q <= {flags_q[23:0], head_tok.data};
				OP_SID: begin
					acc_q <= vnext;
					if (head_tok.vdone) begin
						sid_q <= vnext;
					end
				end
				OP_FID: acc_q <= vnext;
				default: begin
				end
			endcase
			if (makes_result) begin
				out_q <= res;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop && makes_result) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_q;

endmodule
`default_nettype wire

// ===== hdl/length_prefixed_frame_header_parser_unit.sv =====
// Top level of the length-prefixed frame header parser.
//
//   Channel  Direction  Handshake           Payload
//   input    in         in_valid/in_stall   in_data (in_item_t)
//   output   out        out_valid/out_stall out_data (out_item_t)
//   config   in         cfg_wr_en           cfg_wr_data (frame size limit)
//
// One stream byte per cycle while in_stall is low; a result is queued when its
// byte is taken and moves into the output register when the back end pops it.
// in_stall rises only when the four-entry request queue is full, which
// happens only while out_stall holds results back.
// Reset clears the parse state, queue and output valid; the limit register
// returns to 16384. No clearing pass is needed.
`default_nettype none
module length_prefixed_frame_header_parser_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [lpfhp_pkg::LIMIT_W-1:0] cfg_wr_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  lpfhp_pkg::in_item_t           in_data,
	output logic                          out_valid,
	input  logic                          out_stall,
	output lpfhp_pkg::out_item_t          out_data
);
	import lpfhp_pkg::*;

	logic [LIMIT_W-1:0] limit_q;
	logic               tok_push;
	token_t             push_tok;
	token_t             head_tok;
	logic               pop;
	q_status_t          q_stat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
		end else if (cfg_wr_en) begin
			limit_q <= cfg_wr_data;
		end
	end

	lpfhp_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.limit    (limit_q),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.q_stat   (q_stat),
		.tok_push (tok_push),
		.tok      (push_tok)
	);

	lpfhp_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (tok_push),
		.push_tok (push_tok),
		.pop      (pop),
		.head_tok (head_tok),
		.stat     (q_stat)
	);

	lpfhp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head_tok  (head_tok),
		.q_stat    (q_stat),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule
`default_nettype wire

// ===== hdl/lpfhp_checker.sv =====
// Port-level checks of the frame header parser, bound to the top level.
`default_nettype none
module lpfhp_checker (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 out_valid,
	input logic                 out_stall,
	input lpfhp_pkg::out_item_t out_data
);
	import lpfhp_pkg::*;

	logic in_frame_q;
	logic out_take;

	assign out_take = out_valid && !out_stall;

	// Track an open frame from the results alone
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
		end else if (out_take) begin
			in_frame_q <= !out_data.last;
		end
	end

	a_reset_quiet: assert property (@(posedge clk) !arst_n |-> !out_valid)
		else $error("result offered during reset");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("stalled result changed");

	a_payload_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		out_take && out_data.out_kind == KIND_PAYLOAD |-> in_frame_q)
		else $error("payload byte outside a frame");

	a_header_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.out_kind == KIND_HEADER
		|-> out_data.last == (out_data.body_len == '0))
		else $error("header last flag disagrees with payload length");

endmodule

bind length_prefixed_frame_header_parser_unit lpfhp_checker u_lpfhp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_data  (out_data)
);
`default_nettype wire

// ===== bench/length_prefixed_frame_header_parser_unit_tb.sv =====
// Self-checking testbench for the length-prefixed frame header parser unit.
`default_nettype none
module length_prefixed_frame_header_parser_unit_tb;
	import lpfhp_pkg::*;

	localparam int CYCLE_LIMIT = 800000;
	localparam int RANDOM_ITEMS = 1000;
	localparam int VARINT_MAX_BYTES = 10;
	localparam int FILL_RANDOM = 0;
	localparam int FILL_HIGH = 1;
	localparam int FILL_LOW = 2;

	typedef enum logic [2:0] {
		ST_LEN,
		ST_TYPE,
		ST_FLAGS,
		ST_SID,
		ST_FID,
		ST_PAYLOAD,
		ST_ERR
	} parse_state_t;

	logic               clk;
	logic               arst_n;
	logic               cfg_wr_en;
	logic [LIMIT_W-1:0] cfg_wr_data;
	logic               in_valid;
	logic               in_stall;
	in_item_t           in_data;
	logic               out_valid;
	logic               out_stall;
	out_item_t          out_data;

	length_prefixed_frame_header_parser_unit uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.in_data     (in_data),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_data    (out_data)
	);

	// Parser state as predicted from the accepted bytes
	parse_state_t       phase;
	logic [31:0]        len_acc;
	logic [31:0]        remaining;
	logic [2:0]         field_count;
	logic [7:0]         held_type;
	logic [31:0]        held_flags;
	logic [63:0]        held_sid;
	logic [63:0]        vacc;
	logic [6:0]         vshift;
	logic [LIMIT_W-1:0] size_limit;

	out_item_t   parsed_records[$];
	logic [7:0]  body_q[$];
	int          bad_records;
	int          clk_cycles;
	int          counted_items;
	int          send_pct;
	int          recv_pct;
	int          hold_left;
	int          stall_left;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		clk_cycles++;
		if (clk_cycles > CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(99);
		if (r < 80)
			return $urandom_range(3, 1);
		else if (r < 97)
			return $urandom_range(12, 4);
		return $urandom_range(60, 20);
	endfunction

	// Receiver: a counted hold-off overrides the random stalls
	initial begin
		out_stall = 1'b0;
		hold_left = 0;
		stall_left = 0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else if (stall_left > 0) begin
				out_stall <= 1'b1;
				stall_left--;
			end else if (recv_pct != 0 && $urandom_range(99) < recv_pct) begin
				out_stall <= 1'b1;
				stall_left = pick_gap() - 1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	task automatic clear_parse_state();
		phase = ST_LEN;
		len_acc = '0;
		remaining = '0;
		field_count = '0;
		held_type = '0;
		held_flags = '0;
		held_sid = '0;
		vacc = '0;
		vshift = '0;
	endtask

	task automatic absorb_varint_byte(input logic [7:0] b, output bit done);
		if (vshift == 0) begin
			vacc = {56'd0, b};
			done = b < VARINT_ESCAPE;
			if (!done)
				vshift = 7'(VARINT_SHIFT0);
		end else begin
			vacc = vacc + ({56'd0, b} << vshift[5:0]);
			vshift = vshift + 7'(VARINT_SHIFT_STEP);
			done = (b < VARINT_MORE) || (vshift >= 7'd64);
		end
	endtask

	task automatic parse_stream_byte(input in_item_t it);
		out_item_t   rec;
		bit          emit;
		bit          err_hit;
		bit          done;
		logic [1:0]  err_code;
		logic [7:0]  b;
		logic [31:0] cap;
		rec = '0;
		emit = 1'b0;
		err_hit = 1'b0;
		err_code = ERR_BAD_LEN;
		b = it.in_byte;
		if (it.kind == IN_RESTART) begin
			clear_parse_state();
		end else begin
			case (phase)
				ST_LEN: begin
					len_acc = {len_acc[23:0], b};
					field_count++;
					if (field_count == 3'd4) begin
						field_count = '0;
						cap = (32'(size_limit) < MAX_FRAME) ? 32'(size_limit) : MAX_FRAME;
						if (len_acc == 0 || len_acc > cap) begin
							err_hit = 1'b1;
							err_code = ERR_BAD_LEN;
						end else if (len_acc < SHORT_LEN) begin
							err_hit = 1'b1;
							err_code = ERR_SHORT;
						end else begin
							remaining = len_acc;
							phase = ST_TYPE;
						end
					end
				end
				ST_TYPE: begin
					held_type = b;
					remaining--;
					held_flags = '0;
					field_count = '0;
					phase = ST_FLAGS;
				end
				ST_FLAGS: begin
					held_flags = {held_flags[23:0], b};
					remaining--;
					field_count++;
					if (field_count == 3'd4) begin
						field_count = '0;
						if (remaining == 0) begin
							err_hit = 1'b1;
							err_code = ERR_VARINT;
						end else begin
							vshift = '0;
							phase = ST_SID;
						end
					end
				end
				ST_SID: begin
					absorb_varint_byte(b, done);
					remaining--;
					if (done) begin
						held_sid = vacc;
						vshift = '0;
						phase = ST_FID;
					end
					// a finished stream id still fails if no frame id can follow
					if (remaining == 0) begin
						err_hit = 1'b1;
						err_code = ERR_VARINT;
					end
				end
				ST_FID: begin
					absorb_varint_byte(b, done);
					remaining--;
					if (!done) begin
						if (remaining == 0) begin
							err_hit = 1'b1;
							err_code = ERR_VARINT;
						end
					end else begin
						vshift = '0;
						rec.out_kind = KIND_HEADER;
						rec.frame_type = held_type;
						rec.frame_flags = held_flags;
						rec.strm_ident = held_sid;
						rec.frm_ident = vacc;
						rec.body_len = remaining[LIMIT_W-1:0];
						rec.last = remaining == 0;
						emit = 1'b1;
						phase = (remaining == 0) ? ST_LEN : ST_PAYLOAD;
						len_acc = '0;
					end
				end
				ST_PAYLOAD: begin
					remaining--;
					rec.out_kind = KIND_PAYLOAD;
					rec.payload_byte = b;
					emit = 1'b1;
					if (remaining == 0) begin
						rec.last = 1'b1;
						phase = ST_LEN;
						len_acc = '0;
					end
				end
				default: ;
			endcase
			if (err_hit) begin
				rec = '0;
				rec.out_kind = KIND_ERROR;
				rec.last = 1'b1;
				rec.error_code = err_code;
				emit = 1'b1;
				phase = ST_ERR;
			end
		end
		if (emit)
			parsed_records.push_back(rec);
	endtask

	always @(posedge clk) begin : result_check
		out_item_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (parsed_records.size() == 0) begin
				bad_records++;
				if (bad_records <= 10)
					$display("cycle %0d: result with none due: %h", clk_cycles, out_data);
			end else begin
				want = parsed_records.pop_front();
				if (out_data.out_kind !== want.out_kind ||
						out_data.frame_type !== want.frame_type ||
						out_data.frame_flags !== want.frame_flags ||
						out_data.strm_ident !== want.strm_ident ||
						out_data.frm_ident !== want.frm_ident ||
						out_data.body_len !== want.body_len ||
						out_data.payload_byte !== want.payload_byte ||
						out_data.last !== want.last ||
						out_data.error_code !== want.error_code) begin
					bad_records++;
					if (bad_records <= 10) begin
						$display("cycle %0d: expected kind %0d type %h flags %h sid %h fid %h",
							clk_cycles, want.out_kind, want.frame_type, want.frame_flags,
							want.strm_ident, want.frm_ident);
						$display("  len %0d byte %h last %b code %0d", want.body_len,
							want.payload_byte, want.last, want.error_code);
						$display("  actual kind %0d type %h flags %h sid %h fid %h",
							out_data.out_kind, out_data.frame_type, out_data.frame_flags,
							out_data.strm_ident, out_data.frm_ident);
						$display("  len %0d byte %h last %b code %0d", out_data.body_len,
							out_data.payload_byte, out_data.last, out_data.error_code);
					end
				end
			end
		end
	end

	task automatic send_item(input logic k, input logic [7:0] b);
		int       gap;
		in_item_t it;
		it.kind = k;
		it.in_byte = b;
		if (send_pct != 0 && $urandom_range(99) < send_pct) begin
			gap = pick_gap();
			repeat (gap) begin
				@(negedge clk);
				in_valid <= 1'b0;
			end
		end
		@(negedge clk);
		in_valid <= 1'b1;
		in_data <= it;
		// hold the request until it is taken
		do @(posedge clk); while (in_stall);
		if (!(phase == ST_ERR && k == IN_BYTE))
			counted_items++;
		parse_stream_byte(it);
	endtask

	task automatic wait_results_drained();
		@(negedge clk);
		in_valid <= 1'b0;
		while (parsed_records.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_size_limit(input logic [LIMIT_W-1:0] v);
		wait_results_drained();
		// a restart or an ignored byte leaves nothing to wait on, so let it settle
		repeat (4) @(posedge clk);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		size_limit = v;
	endtask

	task automatic restart_parser();
		send_item(IN_RESTART, 8'($urandom_range(255)));
	endtask

	task automatic send_noise(input int n);
		repeat (n) send_item(IN_BYTE, 8'($urandom_range(255)));
	endtask

	task automatic send_len(input logic [31:0] l);
		for (int i = 3; i >= 0; i--)
			send_item(IN_BYTE, l[i*8 +: 8]);
	endtask

	task automatic send_body(input int n);
		for (int i = 0; i < n && i < body_q.size(); i++)
			send_item(IN_BYTE, body_q[i]);
	endtask

	function automatic logic [7:0] draw_byte(input int lo, input int hi, input int fill);
		if (fill == FILL_HIGH)
			return 8'(hi);
		else if (fill == FILL_LOW)
			return 8'(lo);
		return 8'($urandom_range(hi, lo));
	endfunction

	task automatic push_varint(input int n, input int fill);
		for (int i = 0; i < n; i++) begin
			if (i == 0)
				body_q.push_back(n == 1 ? draw_byte(0, int'(VARINT_ESCAPE) - 1, fill)
					: draw_byte(int'(VARINT_ESCAPE), 255, fill));
			else if (i == VARINT_MAX_BYTES - 1)
				body_q.push_back(draw_byte(0, 255, fill));
			else if (i == n - 1)
				body_q.push_back(draw_byte(0, int'(VARINT_MORE) - 1, fill));
			else
				body_q.push_back(draw_byte(int'(VARINT_MORE), 255, fill));
		end
	endtask

	task automatic build_body(input int sid_n, input int fid_n, input int plen, input int fill);
		body_q.delete();
		repeat (5) body_q.push_back(draw_byte(0, 255, fill));
		push_varint(sid_n, fill);
		push_varint(fid_n, fill);
		repeat (plen) body_q.push_back(draw_byte(0, 255, fill));
	endtask

	task automatic post_frame(input int sid_n, input int fid_n, input int plen, input int fill);
		build_body(sid_n, fid_n, plen, fill);
		send_len(body_q.size());
		send_body(body_q.size());
	endtask

	function automatic int random_varint_len();
		int r;
		r = $urandom_range(99);
		if (r < 60)
			return 1;
		else if (r < 85)
			return $urandom_range(3, 2);
		return $urandom_range(VARINT_MAX_BYTES, 4);
	endfunction

	task automatic test_field_extremes();
		post_frame(1, 1, 0, FILL_LOW);
		post_frame(1, 1, 0, FILL_HIGH);
		post_frame(VARINT_MAX_BYTES, VARINT_MAX_BYTES, 2, FILL_HIGH);
		post_frame(VARINT_MAX_BYTES, VARINT_MAX_BYTES, 1, FILL_LOW);
		post_frame(2, 9, 3, FILL_RANDOM);
	endtask

	task automatic test_largest_length();
		build_body(1, 1, 2, FILL_RANDOM);
		send_len(MAX_FRAME);
		send_body(body_q.size());
		restart_parser();
		send_len(MAX_FRAME + 1);
		send_noise(2);
		restart_parser();
	endtask

	task automatic test_framing_errors();
		send_len(0);
		send_noise(3);
		restart_parser();
		send_len(1);
		restart_parser();
		send_len(4);
		restart_parser();
		// frame ends right after the flags
		build_body(1, 1, 0, FILL_RANDOM);
		send_len(5);
		send_body(5);
		restart_parser();
		// stream id complete but nothing left for the frame id
		send_len(6);
		send_body(6);
		restart_parser();
		build_body(2, 1, 0, FILL_RANDOM);
		send_len(6);
		send_body(6);
		restart_parser();
		build_body(1, 4, 0, FILL_RANDOM);
		send_len(9);
		send_body(9);
		restart_parser();
		// drop a frame midway, in the header and then in the payload
		build_body(2, 2, 5, FILL_RANDOM);
		send_len(body_q.size());
		send_body(7);
		restart_parser();
		build_body(1, 1, 6, FILL_RANDOM);
		send_len(body_q.size());
		send_body(10);
		restart_parser();
		post_frame(1, 1, 1, FILL_RANDOM);
	endtask

	task automatic test_limit_settings();
		write_size_limit('0);
		post_frame(1, 1, 0, FILL_RANDOM);
		restart_parser();
		write_size_limit(LIMIT_W'(1));
		send_len(1);
		send_noise(1);
		restart_parser();
		send_len(2);
		restart_parser();
		write_size_limit(LIMIT_W'(5));
		build_body(1, 1, 0, FILL_RANDOM);
		send_len(5);
		send_body(5);
		restart_parser();
		send_len(6);
		restart_parser();
		write_size_limit(LIMIT_W'(7));
		post_frame(1, 1, 0, FILL_RANDOM);
		post_frame(1, 1, 1, FILL_RANDOM);
		restart_parser();
		write_size_limit('1);
		send_len(MAX_FRAME + 1);
		restart_parser();
		post_frame(2, 2, 4, FILL_RANDOM);
		write_size_limit(LIMIT_RESET);
	endtask

	task automatic test_backpressure();
		wait_results_drained();
		send_pct = 0;
		recv_pct = 0;
		hold_left = 300;
		post_frame(1, 1, 120, FILL_RANDOM);
		wait_results_drained();
	endtask

	task automatic test_random_traffic();
		int          base;
		int          r;
		int          plen;
		int          cut;
		logic [31:0] l;
		logic [31:0] cap;
		int          pct_choices[5];
		pct_choices = '{0, 0, 15, 40, 70};
		base = counted_items;
		while (counted_items - base < RANDOM_ITEMS) begin
			if ($urandom_range(19) == 0) begin
				send_pct = pct_choices[$urandom_range(3)];
				recv_pct = pct_choices[$urandom_range(4)];
			end
			if ($urandom_range(99) < 3) begin
				r = $urandom_range(9);
				if (r == 0)
					write_size_limit(LIMIT_W'($urandom_range(6, 1)));
				else if (r == 1)
					write_size_limit(LIMIT_W'($urandom_range(32767, MAX_FRAME + 1)));
				else
					write_size_limit(LIMIT_W'($urandom_range(MAX_FRAME, 64)));
			end
			r = $urandom_range(99);
			if (r < 70) begin
				cut = $urandom_range(99);
				plen = (cut < 70) ? $urandom_range(12, 0) :
					(cut < 95) ? $urandom_range(48, 13) : $urandom_range(200, 49);
				post_frame(random_varint_len(), random_varint_len(), plen, FILL_RANDOM);
			end else if (r < 82) begin
				build_body(random_varint_len(), random_varint_len(), $urandom_range(4),
					FILL_RANDOM);
				l = $urandom_range(body_q.size(), 1);
				send_len(l);
				send_body(l);
			end else if (r < 88) begin
				cap = (32'(size_limit) < MAX_FRAME) ? 32'(size_limit) : MAX_FRAME;
				case ($urandom_range(2))
					0: l = '0;
					1: l = cap + 1;
					default: l = $urandom | 32'h0001_0000;
				endcase
				send_len(l);
				send_noise($urandom_range(3));
				restart_parser();
			end else if (r < 94) begin
				build_body(random_varint_len(), random_varint_len(), $urandom_range(8),
					FILL_RANDOM);
				send_len(body_q.size());
				send_body($urandom_range(body_q.size() - 1));
				restart_parser();
			end else begin
				send_noise($urandom_range(6, 1));
				restart_parser();
			end
			if (phase == ST_ERR) begin
				send_noise($urandom_range(3));
				restart_parser();
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		bad_records = 0;
		clk_cycles = 0;
		counted_items = 0;
		send_pct = 20;
		recv_pct = 20;
		clear_parse_state();
		size_limit = LIMIT_RESET;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_field_extremes();
		test_largest_length();
		test_framing_errors();
		test_limit_settings();
		test_backpressure();
		test_random_traffic();

		wait_results_drained();
		repeat (8) @(posedge clk);
		if (bad_records == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
`default_nettype wire

// ===== filelist.f =====
hdl/lpfhp_pkg.sv
hdl/lpfhp_front.sv
hdl/lpfhp_queue.sv
hdl/lpfhp_back.sv
hdl/length_prefixed_frame_header_parser_unit.sv
hdl/lpfhp_checker.sv
bench/length_prefixed_frame_header_parser_unit_tb.sv
